[rtl/assert_macros.svh]
// Assertion macros shared by the border entrance finder RTL.
// Included by the top level; relies on i_clk and i_rst_n in scope for BEF_ASSERT.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an explicit clock and active-low reset.
`define BEF_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock and reset.
`define BEF_ASSERT(label, prop, msg) `BEF_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

[rtl/bef_pkg.sv]
// Package for the border entrance finder: field widths, job and write-port structs.
// No dependencies; imported by every module of the block.
package bef_pkg;

    localparam int POS_W  = 6;   // positions up to the largest cluster size
    localparam int LEN_W  = 7;   // run length up to the largest cluster size
    localparam int SPOS_W = 8;   // signed search positions, one beyond either end
    localparam int CLR_W  = 4;
    localparam int THR_W  = 5;
    localparam int OPOS_W = 4;

    localparam logic [THR_W-1:0] THR_RESET = 5'd12;
    localparam logic signed [SPOS_W-1:0] S_ONE = 8'sd1;

    typedef logic [CLR_W-1:0] t_clear;
    typedef logic [POS_W-1:0] t_pos;
    typedef logic [LEN_W-1:0] t_len;
    typedef logic signed [SPOS_W-1:0] t_spos;

    // One finished run handed from the front to the back.
    typedef struct packed {
        logic   bank;
        t_pos   lo;
        t_pos   hi;
        t_len   len;
        t_clear max;
        logic   split;
    } t_job;

    // Run buffer write from the front.
    typedef struct packed {
        logic   we;
        logic   bank;
        t_pos   idx;
        t_clear data;
    } t_wr;

endpackage

[rtl/bef_if.sv]
// Channel interfaces of the border entrance finder: cell input and entrance output.
// Depends on bef_pkg for the field types.
interface bef_cell_if;
    import bef_pkg::*;
    logic   valid;
    logic   ready;
    t_clear clearance_a;
    t_clear clearance_b;
    logic   last_cell;

    modport source (output valid, clearance_a, clearance_b, last_cell, input ready);
    modport sink   (input valid, clearance_a, clearance_b, last_cell, output ready);
endinterface

interface bef_ent_if;
    import bef_pkg::*;
    logic                valid;
    logic                ready;
    logic [OPOS_W-1:0]   entrance_position;
    t_clear              entrance_clearance;
    logic                last_of_run;

    modport source (output valid, entrance_position, entrance_clearance, last_of_run,
                    input ready);
    modport sink   (input valid, entrance_position, entrance_clearance, last_of_run,
                    output ready);
endinterface

[rtl/bef_front.sv]
// Front part: accepts cells, tracks the current run, writes the run buffer, posts jobs.
// Depends on bef_pkg.
module bef_front import bef_pkg::*; #(
    parameter int CLUSTER_SIZE = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_clear           i_clearance_a,
    input  t_clear           i_clearance_b,
    input  logic             i_last_cell,
    input  logic             i_q_full,
    output logic             o_push,
    output t_job             o_job,
    output t_wr              o_wr
);

    localparam t_pos LAST_POS = POS_W'(CLUSTER_SIZE - 1);
    localparam t_len MAX_LEN  = LEN_W'(CLUSTER_SIZE);

    logic             r_in_run, n_in_run;
    t_len             r_len, n_len;
    t_pos             r_start, n_start;
    t_pos             r_end, n_end;
    t_clear           r_max, n_max;
    t_pos             r_scan, n_scan;
    logic             r_bank, n_bank;
    logic [THR_W-1:0] r_thr;

    logic   accept, last, end_run;
    t_clear local_clr, base_max, new_max;
    t_len   base_len, new_len;
    t_pos   pos, base_start, new_end;

    assign o_ready   = !i_q_full;
    assign accept    = i_valid && o_ready;
    assign local_clr = (i_clearance_a < i_clearance_b) ? i_clearance_a : i_clearance_b;
    assign last      = i_last_cell || (r_scan == LAST_POS);
    assign pos       = LAST_POS - r_scan;

    always_comb begin
        base_len   = r_in_run ? r_len : '0;
        base_max   = r_in_run ? r_max : '0;
        base_start = r_in_run ? r_start : pos;
        new_len    = base_len;
        new_max    = base_max;
        new_end    = r_end;
        end_run    = 1'b0;
        o_wr.we    = 1'b0;
        o_wr.bank  = r_bank;
        o_wr.idx   = base_len[POS_W-1:0];
        o_wr.data  = local_clr;

        if (local_clr != '0) begin
            if (base_len < MAX_LEN) begin
                o_wr.we = accept;
                new_len = base_len + LEN_W'(1);
            end
            new_end = pos;
            if (local_clr > base_max) begin
                new_max = local_clr;
            end
            end_run = last;
        end else begin
            end_run    = r_in_run;
            base_start = r_start;
        end

        o_push      = accept && end_run;
        o_job.bank  = r_bank;
        o_job.lo    = new_end;
        o_job.hi    = base_start;
        o_job.len   = new_len;
        o_job.max   = new_max;
        o_job.split = (new_len >= LEN_W'(r_thr));

        n_in_run = r_in_run;
        n_len    = r_len;
        n_start  = r_start;
        n_end    = r_end;
        n_max    = r_max;
        n_scan   = r_scan;
        n_bank   = r_bank;
        if (accept) begin
            n_scan = last ? '0 : r_scan + POS_W'(1);
            if (end_run) begin
                n_in_run = 1'b0;
                n_len    = '0;
                n_max    = '0;
                n_start  = base_start;
                n_end    = new_end;
                n_bank   = !r_bank;
            end else if (local_clr != '0) begin
                n_in_run = 1'b1;
                n_len    = new_len;
                n_max    = new_max;
                n_start  = base_start;
                n_end    = new_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run <= 1'b0;
            r_len    <= '0;
            r_start  <= '0;
            r_end    <= '0;
            r_max    <= '0;
            r_scan   <= '0;
            r_bank   <= 1'b0;
            r_thr    <= THR_RESET;
        end else begin
            r_in_run <= n_in_run;
            r_len    <= n_len;
            r_start  <= n_start;
            r_end    <= n_end;
            r_max    <= n_max;
            r_scan   <= n_scan;
            r_bank   <= n_bank;
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
        end
    end

endmodule

[rtl/bef_queue.sv]
// Two-entry job queue between the front and the back of the entrance finder.
// Depends on bef_pkg for the job struct.
module bef_queue import bef_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

[rtl/bef_back.sv]
// Back part: holds the two-bank run buffer and runs the centre-outward searches.
// Depends on bef_pkg; takes jobs from bef_queue and drives the entrance channel.
module bef_back import bef_pkg::*; #(
    parameter int CLUSTER_SIZE = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_wr               i_wr,
    input  logic              i_job_valid,
    input  t_job              i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [OPOS_W-1:0] o_position,
    output t_clear            o_clearance,
    output logic              o_last
);

    localparam int PW    = $clog2(CLUSTER_SIZE);
    localparam int DEPTH = 2 ** (PW + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    localparam logic [1:0] PH_A    = 2'd0;
    localparam logic [1:0] PH_B    = 2'd1;
    localparam logic [1:0] PH_FULL = 2'd2;

    t_clear r_mem [DEPTH];
    t_clear r_rdata;

    logic [1:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    t_spos      r_low, n_low, r_high, n_high, r_incr, n_incr, r_p, n_p;
    logic       r_up, n_up;
    t_pos       r_pos_a, n_pos_a, r_pos_b, n_pos_b;
    logic       r_second, n_second;
    logic       r_out_valid, n_out_valid;
    t_pos       r_out_pos, n_out_pos;
    logic       r_out_last, n_out_last;
    t_clear     r_out_clr, n_out_clr;

    t_spos span, half, centre, stop, p, idx, lo_s, hi_s, mid_s, len_s;
    t_pos  mid;
    logic  in_range, done_ev, hit;
    t_pos  hit_pos;
    logic [PW:0] raddr;

    assign lo_s  = t_spos'({2'b00, i_job.lo});
    assign hi_s  = t_spos'({2'b00, i_job.hi});
    assign len_s = t_spos'({1'b0, i_job.len});
    assign mid   = i_job.lo + ((i_job.hi - i_job.lo) >> 1);
    assign mid_s = t_spos'({2'b00, mid});

    // Centre of the current search window, truncating toward zero.
    assign span     = r_high - r_low;
    assign half     = span[SPOS_W-1] ? ((span + S_ONE) >>> 1) : (span >>> 1);
    assign centre   = r_low + half;
    assign stop     = span[0] ? (r_low - S_ONE) : (r_high + S_ONE);
    assign p        = r_up ? (centre + r_incr) : (centre - r_incr);
    assign idx      = hi_s - p;
    assign in_range = !idx[SPOS_W-1] && (idx < len_s);
    assign raddr    = {i_job.bank, idx[PW-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[{i_wr.bank, i_wr.idx[PW-1:0]}] <= i_wr.data;
        end
        r_rdata <= r_mem[raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_low       = r_low;
        n_high      = r_high;
        n_incr      = r_incr;
        n_up        = r_up;
        n_p         = r_p;
        n_pos_a     = r_pos_a;
        n_pos_b     = r_pos_b;
        n_second    = r_second;
        n_out_valid = r_out_valid;
        n_out_pos   = r_out_pos;
        n_out_last  = r_out_last;
        n_out_clr   = r_out_clr;
        o_pop       = 1'b0;
        done_ev     = 1'b0;
        hit         = 1'b0;
        hit_pos     = r_p[POS_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_incr  = '0;
                    n_up    = 1'b0;
                    n_low   = lo_s;
                    n_state = S_ISSUE;
                    if (i_job.split) begin
                        n_phase = PH_A;
                        n_high  = mid_s - S_ONE;
                    end else begin
                        n_phase = PH_FULL;
                        n_high  = hi_s;
                    end
                end
            end
            S_ISSUE: begin
                if (p == stop) begin
                    done_ev = 1'b1;
                end else if (in_range) begin
                    n_p     = p;
                    n_state = S_CHECK;
                end else begin
                    n_up   = !r_up;
                    n_incr = r_up ? r_incr : r_incr + S_ONE;
                end
            end
            S_CHECK: begin
                if (r_rdata == i_job.max) begin
                    done_ev = 1'b1;
                    hit     = 1'b1;
                end else begin
                    n_up    = !r_up;
                    n_incr  = r_up ? r_incr : r_incr + S_ONE;
                    n_state = S_ISSUE;
                end
            end
            S_EMIT: begin
                if (i_ready) begin
                    if (r_second) begin
                        n_out_pos  = r_pos_b;
                        n_out_last = 1'b1;
                        n_second   = 1'b0;
                    end else begin
                        n_out_valid = 1'b0;
                        o_pop       = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // End of one search: pick the next search or load the result register.
        if (done_ev) begin
            n_incr  = '0;
            n_up    = 1'b0;
            n_state = S_ISSUE;
            if (r_phase == PH_A && hit) begin
                n_pos_a = hit_pos;
                n_phase = PH_B;
                n_low   = mid_s;
                n_high  = hi_s;
            end else if (r_phase == PH_B && hit) begin
                n_pos_b     = hit_pos;
                n_second    = 1'b1;
                n_out_valid = 1'b1;
                n_out_pos   = r_pos_a;
                n_out_last  = 1'b0;
                n_out_clr   = i_job.max;
                n_state     = S_EMIT;
            end else if (r_phase == PH_FULL) begin
                n_second    = 1'b0;
                n_out_valid = 1'b1;
                n_out_pos   = hit ? hit_pos : i_job.lo;
                n_out_last  = 1'b1;
                n_out_clr   = i_job.max;
                n_state     = S_EMIT;
            end else begin
                n_phase = PH_FULL;
                n_low   = lo_s;
                n_high  = hi_s;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_FULL;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_second    <= n_second;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low      <= n_low;
        r_high     <= n_high;
        r_incr     <= n_incr;
        r_up       <= n_up;
        r_p        <= n_p;
        r_pos_a    <= n_pos_a;
        r_pos_b    <= n_pos_b;
        r_out_pos  <= n_out_pos;
        r_out_last <= n_out_last;
        r_out_clr  <= n_out_clr;
    end

    assign o_valid     = r_out_valid;
    assign o_position  = r_out_pos[OPOS_W-1:0];
    assign o_clearance = r_out_clr;
    assign o_last      = r_out_last;

endmodule

[rtl/border_entrance_finder.sv]
// Slowest case: a split run that falls back to one full search after a half search misses.
// Throughput: one cell per cycle into the front while the two-entry job queue has room;
// the back examines each in-range candidate with a buffer read and then a compare.
// Reset: synchronous, active low; clears run tracking, queue and sequencer; the run
// buffer needs no clearing pass since every read hits an entry written in that run.
`include "assert_macros.svh"

module border_entrance_finder import bef_pkg::*; #(
    parameter int CLUSTER_SIZE = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_data,
    bef_cell_if.sink         i_cell,
    bef_ent_if.source        o_ent
);

    // The front walks the border one cell per transfer. Each cell's clearance is
    // the smaller of its two sides; consecutive clear cells build a run whose
    // clearances go into one bank of the run buffer. When the run ends, the front
    // posts a job (bounds, length, maximum, bank, split decision) into the queue
    // and switches to the other bank for the next run.

    logic q_push, q_pop, q_full, q_valid;
    t_job push_job, head_job;
    t_wr  wr;

    bef_front #(
        .CLUSTER_SIZE(CLUSTER_SIZE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_cell.valid),
        .o_ready       (i_cell.ready),
        .i_clearance_a (i_cell.clearance_a),
        .i_clearance_b (i_cell.clearance_b),
        .i_last_cell   (i_cell.last_cell),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_job         (push_job),
        .o_wr          (wr)
    );

    // Two jobs at most can wait, which matches the two buffer banks: the front
    // stalls while the queue is full, so it never writes the bank being searched.
    bef_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // The back runs the centre-outward searches over the head job's bank and
    // emits one or two entrances through its output register. The job leaves
    // the queue when the last entrance of the run is transferred.
    bef_back #(
        .CLUSTER_SIZE(CLUSTER_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_job_valid (q_valid),
        .i_job       (head_job),
        .o_pop       (q_pop),
        .o_valid     (o_ent.valid),
        .i_ready     (o_ent.ready),
        .o_position  (o_ent.entrance_position),
        .o_clearance (o_ent.entrance_clearance),
        .o_last      (o_ent.last_of_run)
    );

    // A job is only posted when the queue has room.
    `BEF_ASSERT(a_no_overflow, q_push |-> !q_full, "job pushed into a full queue")
    // A job is only retired when one is present.
    `BEF_ASSERT(a_no_underflow, q_pop |-> q_valid, "job popped from an empty queue")
    // The front never writes the bank that the back is searching.
    `BEF_ASSERT(a_bank_split, (wr.we && q_valid) |-> (wr.bank != head_job.bank),
        "run buffer write hit the bank under search")
    // The first of two entrances is followed directly by the second.
    `BEF_ASSERT(a_pair_follows,
        (o_ent.valid && o_ent.ready && !o_ent.last_of_run) |=>
        (o_ent.valid && o_ent.last_of_run),
        "second entrance of a split run did not follow")

endmodule

[dv/tb.sv]
// Self-checking testbench for border_entrance_finder: directed border scans, then random scans.
// Depends on bef_pkg and the bef_cell_if / bef_ent_if interfaces of the RTL.
// Expected entrances come from a cycle-free predictor of the run search and are checked in order.
module tb;
    import bef_pkg::*;

    localparam int CLUSTER_CELLS = 16;
    // Longest quiet time the block may still need after its last entrance:
    // two queued jobs, each with up to three searches over a full run.
    localparam int SETTLE_CYCLES = 300;
    localparam int LIMIT_TIME    = 20 * 400_000;

    typedef struct packed {
        logic [OPOS_W-1:0] position;
        t_clear            clearance;
        logic              last_of_run;
    } t_entrance;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [THR_W-1:0] i_cfg_data;

    bef_cell_if cell_if();
    bef_ent_if  ent_if();

    border_entrance_finder #(.CLUSTER_SIZE(CLUSTER_CELLS)) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_cell    (cell_if),
        .o_ent     (ent_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor state: the open run, its buffered clearances and the scan position.
    t_clear           run_buf [CLUSTER_CELLS];
    bit               run_open;
    int               run_len;
    int               run_top;
    int               run_bottom;
    t_clear           run_peak;
    int               scan_idx;
    logic [THR_W-1:0] split_thr;

    t_entrance expected_entrances[$];
    t_entrance oldest;
    int        mismatches;
    int        cells_sent;
    int        sender_idle_pct;
    int        recv_stall_pct;

    // Centre-outward search of [low,high] for a cell holding the run peak.
    // The walk starts at the midpoint, tries +1, -1, +2, -2 and so on, and stops
    // one past the end that the parity of the span points to. Returns -1 if none.
    function automatic int centre_pick(int low, int high);
        int span, centre, stop, incr, p, idx;
        bit up;
        span   = high - low;
        centre = low + span / 2;
        stop   = (span % 2 != 0) ? low - 1 : high + 1;
        incr   = 0;
        up     = 1'b0;
        for (int g = 0; g < 4 * CLUSTER_CELLS + 8; g++) begin
            p = up ? centre + incr : centre - incr;
            if (p == stop) begin
                return -1;
            end
            idx = run_top - p;
            if (idx >= 0 && idx < run_len && idx < CLUSTER_CELLS &&
                run_buf[idx] == run_peak) begin
                return p;
            end
            up = !up;
            if (up) begin
                incr++;
            end
        end
        return -1;
    endfunction

    task automatic add_expected(input int pos, input logic last);
        t_entrance e;
        e.position    = pos[OPOS_W-1:0];
        e.clearance   = run_peak;
        e.last_of_run = last;
        expected_entrances = {expected_entrances, e};
    endtask

    // A long run looks for the peak in each half; only when both halves hold it
    // are two entrances placed, otherwise one centre search covers the whole run.
    task automatic close_run();
        int lo, hi, d, a, b, p;
        lo = run_bottom;
        hi = run_top;
        d  = hi - lo;
        if (run_len >= split_thr) begin
            a = centre_pick(lo, lo + d / 2 - 1);
            if (a >= 0) begin
                b = centre_pick(lo + d / 2, hi);
                if (b >= 0) begin
                    add_expected(a, 1'b0);
                    add_expected(b, 1'b1);
                    return;
                end
            end
        end
        p = centre_pick(lo, hi);
        if (p < 0) begin
            p = lo;
        end
        add_expected(p, 1'b1);
    endtask

    task automatic predict_cell(input t_clear a, input t_clear b, input logic last_in);
        logic   last;
        t_clear clr;
        int     pos;
        bit     ends;
        // The sixteenth cell of a scan closes the border whatever last_cell says.
        last = last_in || scan_idx >= CLUSTER_CELLS - 1;
        clr  = (a < b) ? a : b;
        pos  = CLUSTER_CELLS - 1 - scan_idx;
        ends = 1'b0;
        if (clr != 0) begin
            if (!run_open) begin
                run_open = 1'b1;
                run_top  = pos;
                run_len  = 0;
                run_peak = '0;
            end
            if (run_len < CLUSTER_CELLS) begin
                run_buf[run_len] = clr;
                run_len++;
            end
            run_bottom = pos;
            if (clr > run_peak) begin
                run_peak = clr;
            end
            if (last) begin
                ends = 1'b1;
            end
        end else if (run_open) begin
            ends = 1'b1;
        end
        if (ends) begin
            close_run();
            run_open = 1'b0;
            run_len  = 0;
            run_peak = '0;
        end
        scan_idx = last ? 0 : scan_idx + 1;
    endtask

    // Sends one cell pair; called and returning at a falling edge.
    task automatic send_cell(input t_clear a, input t_clear b, input logic last);
        int gaps;
        gaps = 0;
        while ($urandom_range(99) < sender_idle_pct) begin
            gaps++;
        end
        if (gaps > 0) begin
            cell_if.valid = 1'b0;
            repeat (gaps) @(negedge i_clk);
        end
        cell_if.valid       = 1'b1;
        cell_if.clearance_a = a;
        cell_if.clearance_b = b;
        cell_if.last_cell   = last;
        do begin
            @(posedge i_clk);
        end while (!cell_if.ready);
        predict_cell(a, b, last);
        cells_sent++;
        @(negedge i_clk);
    endtask

    // Threshold writes only happen with no run open and the block drained.
    task automatic set_split(input logic [THR_W-1:0] value);
        cell_if.valid = 1'b0;
        wait (expected_entrances.size() == 0);
        @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we  = 1'b0;
        split_thr = value;
    endtask

    // Blocked cells on either side, then a one-cell run closed by a blocked cell.
    task automatic test_blocked_cells();
        send_cell(4'd0,  4'd0,  1'b0);
        send_cell(4'd0,  4'd15, 1'b0);
        send_cell(4'd15, 4'd0,  1'b0);
        send_cell(4'd15, 4'd15, 1'b0);
        send_cell(4'd0,  4'd5,  1'b0);
        send_cell(4'd0,  4'd0,  1'b1);
    endtask

    // A fully clear border with last_cell never set: the scan wraps by itself, and
    // the run holds its peak once in each half, so two entrances are expected.
    task automatic test_scan_overrun();
        for (int i = 0; i < CLUSTER_CELLS; i++) begin
            send_cell((i == 3 || i == 12) ? 4'd15 : 4'd6, 4'd15, 1'b0);
        end
    endtask

    // A run that reaches the last cell while still clear.
    task automatic test_run_at_last_cell();
        send_cell(4'd0, 4'd0,  1'b0);
        send_cell(4'd9, 4'd3,  1'b0);
        send_cell(4'd4, 4'd12, 1'b1);
    endtask

    // Mostly whole borders with random content; narrow clearance ranges give ties
    // to the peak so the centre and half searches have real choices to make.
    task automatic send_random_border();
        int     len, cap, block_pct;
        t_clear v, other;
        logic   last;
        if ($urandom_range(0, 9) >= 8) begin
            repeat ($urandom_range(1, 6)) begin
                send_cell(t_clear'($urandom_range(0, 15)), t_clear'($urandom_range(0, 15)),
                          $urandom_range(0, 7) == 0);
            end
            return;
        end
        len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, CLUSTER_CELLS) : CLUSTER_CELLS;
        cap = $urandom_range(1, 15);
        case ($urandom_range(0, 2))
            0: begin
                block_pct = 0;
            end
            1: begin
                block_pct = 12;
            end
            default: begin
                block_pct = 35;
            end
        endcase
        for (int i = 0; i < len; i++) begin
            v     = t_clear'($urandom_range(1, cap));
            other = t_clear'($urandom_range(v, 15));
            if ($urandom_range(99) < block_pct) begin
                v = '0;
                if ($urandom_range(0, 3) == 0) begin
                    other = '0;
                end
            end
            last = (i == len - 1) && (len < CLUSTER_CELLS || $urandom_range(0, 1) == 1);
            if ($urandom_range(0, 1) == 1) begin
                send_cell(v, other, last);
            end else begin
                send_cell(other, v, last);
            end
        end
    endtask

    task automatic test_random_phase(input int n_cells, input int idle_pct, input int stall_pct,
                                     input logic [THR_W-1:0] thr, input bit hold_midway);
        int target;
        bit held;
        set_split(thr);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        target = cells_sent + n_cells;
        held   = 1'b0;
        while (cells_sent < target) begin
            // Let the block drain completely once before carrying on.
            if (hold_midway && !held && cells_sent >= target - n_cells / 2) begin
                held          = 1'b1;
                cell_if.valid = 1'b0;
                wait (expected_entrances.size() == 0);
                @(negedge i_clk);
            end
            send_random_border();
        end
        // Close the border so no run is open across the next threshold write.
        send_cell(4'd0, 4'd0, 1'b1);
    endtask

    always @(negedge i_clk) begin
        ent_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ent_if.valid && ent_if.ready) begin
            if (expected_entrances.size() == 0) begin
                $display("%0t: unexpected entrance: got pos %0d clr %0d last %0d", $time,
                         ent_if.entrance_position, ent_if.entrance_clearance,
                         ent_if.last_of_run);
                mismatches++;
            end else begin
                oldest = expected_entrances[0];
                expected_entrances.delete(0);
                if (ent_if.entrance_position !== oldest.position ||
                    ent_if.entrance_clearance !== oldest.clearance ||
                    ent_if.last_of_run !== oldest.last_of_run) begin
                    $display({"%0t: entrance mismatch: expected pos %0d clr %0d last %0d,",
                              " got pos %0d clr %0d last %0d"},
                             $time, oldest.position, oldest.clearance, oldest.last_of_run,
                             ent_if.entrance_position, ent_if.entrance_clearance,
                             ent_if.last_of_run);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #(LIMIT_TIME);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_data          = '0;
        cell_if.valid       = 1'b0;
        cell_if.clearance_a = '0;
        cell_if.clearance_b = '0;
        cell_if.last_cell   = 1'b0;
        ent_if.ready        = 1'b0;
        sender_idle_pct     = 0;
        recv_stall_pct      = 0;
        mismatches          = 0;
        cells_sent          = 0;
        run_open            = 1'b0;
        run_len             = 0;
        run_top             = 0;
        run_bottom          = 0;
        run_peak            = '0;
        scan_idx            = 0;
        split_thr           = THR_RESET;
        foreach (run_buf[i]) begin
            run_buf[i] = '0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_blocked_cells();
        test_scan_overrun();
        test_run_at_last_cell();

        test_random_phase(100, 0,  0,  5'd16, 1'b0);
        test_random_phase(100, 68, 0,  5'd0,  1'b0);
        test_random_phase(100, 0,  68, 5'd1,  1'b0);
        test_random_phase(100, 36, 36, 5'd2,  1'b0);
        test_random_phase(100, 0,  0,  5'd7,  1'b1);
        test_random_phase(100, 36, 36, 5'd12, 1'b0);

        cell_if.valid = 1'b0;
        wait (expected_entrances.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/bef_pkg.sv
rtl/bef_if.sv
rtl/bef_front.sv
rtl/bef_queue.sv
rtl/bef_back.sv
rtl/border_entrance_finder.sv
dv/tb.sv
